@@ sv/bms_pkg.sv @@
// Shared types and constants for the bottom-up merge sorter unit.
package bms_pkg;

  localparam int unsigned KeyWidth = 32;

  typedef logic signed [KeyWidth-1:0] bms_key_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic     insert;  // place key into the sorted row
    logic     shift;   // move the row one place toward cell 0
    bms_key_t key;     // key being inserted
  } bms_ctrl_t;

  // State that a cell shows to its neighbors.
  typedef struct packed {
    logic     valid;   // cell holds a key
    logic     lt;      // incoming key goes at or before this cell
    bms_key_t key;
  } bms_cell_t;

endpackage

@@ sv/bms_if.sv @@
// Valid/ready channel interfaces for key words and result words.
interface bms_key_if import bms_pkg::*; ();
  logic     valid;
  logic     ready;
  bms_key_t key_value;
  logic     item_last;

  modport source (output valid, output key_value, output item_last, input ready);
  modport sink   (input valid, input key_value, input item_last, output ready);
endinterface

interface bms_res_if import bms_pkg::*; ();
  logic     valid;
  logic     ready;
  bms_key_t sorted_value;
  logic     result_last;
  logic     overflowed;

  modport source (output valid, output sorted_value, output result_last,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input result_last,
                  input overflowed, output ready);
endinterface

@@ sv/bottom_up_merge_sorter_unit.sv @@
// Sorter top level: a row of DEPTH cells, loaded one word a cycle, drained in order.
// The first result shows the cycle after the word marked last, then one result
//   a cycle while out_o is ready.
// Loading and draining do not overlap: no key word is taken while a set drains;
//   words that arrive with the row full are taken but dropped, flagging overflow.
// Reset clears the cell valid bits, key count, drop flag and drain state.
module bottom_up_merge_sorter_unit import bms_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bms_key_if.sink   in_i,
  bms_res_if.source out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [CntW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic            drain_q, drain_d;

  logic      in_acc, out_acc, full;
  bms_ctrl_t ctrl;
  bms_cell_t cells [DEPTH];
  bms_cell_t prev_n [DEPTH];
  bms_cell_t next_n [DEPTH];

  // Load while not draining; results come straight from cell 0.
  assign in_i.ready = !drain_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign full       = (count_q == FullCnt);

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;
  assign ctrl.key    = in_i.key_value;

  // Row of cells: each sees its neighbors. Cell 0 takes the key on insert when
  // it is empty or holds a larger key; the tail feeds an empty slot while shifting.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_n[i] = '{valid: 1'b1, lt: 1'b0, key: '0};
    end else begin : g_mid_prev
      assign prev_n[i] = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_n[i] = '{valid: 1'b0, lt: 1'b1, key: '0};
    end else begin : g_mid_next
      assign next_n[i] = cells[i+1];
    end

    bms_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev_n[i]),
      .next_i (next_n[i]),
      .cell_o (cells[i])
    );
  end

  assign out_o.valid        = drain_q;
  assign out_o.sorted_value = cells[0].key;
  assign out_o.result_last  = !cells[1].valid;   // nothing queued behind cell 0
  assign out_o.overflowed   = drop_q;

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    drain_d = drain_q;
    if (in_acc) begin
      if (full) begin
        drop_d = 1'b1;                // key lost, flag the whole set
      end else begin
        count_d = count_q + 1'b1;
      end
      if (in_i.item_last) begin
        drain_d = 1'b1;
      end
    end
    if (out_acc && out_o.result_last) begin
      count_d = '0;
      drop_d  = 1'b0;
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      drain_q <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
      drain_q <= drain_d;
    end
  end

endmodule

@@ sv/bms_cell.sv @@
// One sorting cell: holds a key, inserts in order or shifts toward cell 0.
module bms_cell import bms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bms_ctrl_t ctrl_i,
  input  bms_cell_t prev_i,   // neighbor nearer cell 0
  input  bms_cell_t next_i,   // neighbor farther from cell 0
  output bms_cell_t cell_o
);

  logic     valid_q, valid_d;
  bms_key_t key_q, key_d;
  logic     lt;

  // strict compare keeps equal keys in arrival order
  assign lt = !valid_q || (ctrl_i.key < key_q);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (ctrl_i.shift) begin
      valid_d = next_i.valid;
      key_d   = next_i.key;
    end else if (ctrl_i.insert && lt) begin
      valid_d = valid_q | prev_i.valid;
      key_d   = prev_i.lt ? prev_i.key : ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.lt    = lt;
  assign cell_o.key   = key_q;

endmodule
